### src/u4x_pkg.sv
package u4x_pkg;

	// Item commands.
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_RX_EMPTY = 2'd1;
	localparam logic [1:0] ST_TX_FULL  = 2'd2;

	// Frame phase codes, shared by transmitter and receiver.
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_START = 2'd1;
	localparam logic [1:0] PH_DATA  = 2'd2;
	localparam logic [1:0] PH_STOP  = 2'd3;

	// Tick positions within a frame, at four ticks per bit.
	localparam logic [5:0] TX_START_LAST = 6'd3;
	localparam logic [5:0] RX_START_LAST = 6'd2;
	localparam logic [5:0] DATA_LAST     = 6'd35;
	localparam logic [5:0] TX_STOP_EDGE  = 6'd36;
	localparam logic [5:0] RX_STOP_SAMPLE = 6'd38;
	localparam logic [5:0] STOP_LAST     = 6'd39;
	localparam logic [1:0] TX_BIT_OFS    = 2'd0;
	localparam logic [1:0] RX_SAMPLE_OFS = 2'd2;

	// Transmitter requests towards the FIFO and its pin level.
	typedef struct packed {
		logic pop;
		logic pin_next;
	} tx_ctl_t;

	// Receiver push of a completed word.
	typedef struct packed {
		logic       push;
		logic [7:0] data;
	} rx_ev_t;

endpackage

### src/uart_4x_oversampled_with_fifos.sv
// A result word is registered in stage one and then in the output register.
// Throughput: one item per cycle while the output is not stalled; the FIFO memories
// are read only through their single registered read port, at most one access per item.
// Reset: arst_n clears pointers, fill counts, framing state and pipeline valid flags,
// and sets the transmitter pin state high; the tx_line output register and FIFO memory contents are not cleared.
module uart_4x_oversampled_with_fifos #(
	parameter int TX_DEPTH = 16,
	parameter int RX_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] write_data,
	input  logic       rx_line,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       tx_line,
	output logic [7:0] read_data,
	output logic [1:0] status,
	output logic [4:0] tx_level,
	output logic [4:0] rx_level
);
	import u4x_pkg::*;

	localparam int TX_AW = $clog2(TX_DEPTH);
	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int TX_FW = $clog2(TX_DEPTH + 1);
	localparam int RX_FW = $clog2(RX_DEPTH + 1);
	localparam logic [TX_AW-1:0] TX_PTR_LAST = TX_AW'(TX_DEPTH - 1);
	localparam logic [RX_AW-1:0] RX_PTR_LAST = RX_AW'(RX_DEPTH - 1);
	localparam logic [TX_FW-1:0] TX_FULL_LVL = TX_FW'(TX_DEPTH);
	localparam logic [RX_FW-1:0] RX_FULL_LVL = RX_FW'(RX_DEPTH);

	logic             accept, advance;
	logic             tick;
	logic             tx_wr_ok, rx_rd_ok;
	logic             tx_full, rx_full;
	logic [1:0]       status_d;
	tx_ctl_t          tx_ctl;
	rx_ev_t           rx_ev;
	logic [7:0]       tx_rdata, rx_rdata;

	logic [TX_AW-1:0] tx_wr_ptr_q, tx_rd_ptr_q;
	logic [TX_FW-1:0] tx_fill_q, tx_fill_d;
	logic [RX_AW-1:0] rx_wr_ptr_q, rx_rd_ptr_q;
	logic [RX_FW-1:0] rx_fill_q, rx_fill_d;

	logic             valid_s1;
	logic             pin_s1;
	logic [1:0]       status_s1;
	logic [4:0]       tx_level_s1, rx_level_s1;
	logic             rd_ok_s1;

	logic             out_valid_q;
	logic             tx_line_q;
	logic [7:0]       read_data_q;
	logic [1:0]       status_q;
	logic [4:0]       tx_level_q, rx_level_q;

	// Handshake: the output register frees stage one, stage one frees the input.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// Decode of the accepted word.
	assign tx_full  = (tx_fill_q == TX_FULL_LVL);
	assign rx_full  = (rx_fill_q == RX_FULL_LVL);
	assign tick     = accept && (cmd == CMD_TICK);
	assign tx_wr_ok = accept && (cmd == CMD_WRITE) && !tx_full;
	assign rx_rd_ok = accept && (cmd == CMD_READ) && (rx_fill_q != '0);

	always_comb begin
		case (cmd)
			CMD_WRITE: status_d = tx_full ? ST_TX_FULL : ST_OK;
			CMD_READ:  status_d = (rx_fill_q == '0) ? ST_RX_EMPTY : ST_OK;
			default:   status_d = ST_OK;
		endcase
	end

	// Fill counts after this item; a push and a pop never share an item.
	always_comb begin
		tx_fill_d = tx_fill_q;
		if (tx_wr_ok) begin
			tx_fill_d = tx_fill_q + TX_FW'(1);
		end else if (tx_ctl.pop) begin
			tx_fill_d = tx_fill_q - TX_FW'(1);
		end
		rx_fill_d = rx_fill_q;
		if (rx_ev.push) begin
			rx_fill_d = rx_fill_q + RX_FW'(1);
		end else if (rx_rd_ok) begin
			rx_fill_d = rx_fill_q - RX_FW'(1);
		end
	end

	u4x_tx u_tx (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick),
		.avail     (tx_fill_q != '0),
		.fifo_data (tx_rdata),
		.ctl       (tx_ctl)
	);

	u4x_rx u_rx (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.line   (rx_line),
		.full   (rx_full),
		.ev     (rx_ev)
	);

	u4x_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (tx_wr_ok),
		.waddr (tx_wr_ptr_q),
		.wdata (write_data),
		.re    (tx_ctl.pop),
		.raddr (tx_rd_ptr_q),
		.rdata (tx_rdata)
	);

	u4x_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (rx_ev.push),
		.waddr (rx_wr_ptr_q),
		.wdata (rx_ev.data),
		.re    (rx_rd_ok),
		.raddr (rx_rd_ptr_q),
		.rdata (rx_rdata)
	);

	// FIFO pointers and fill counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_wr_ptr_q <= '0;
			tx_rd_ptr_q <= '0;
			tx_fill_q   <= '0;
			rx_wr_ptr_q <= '0;
			rx_rd_ptr_q <= '0;
			rx_fill_q   <= '0;
		end else begin
			if (tx_wr_ok) begin
				tx_wr_ptr_q <= (tx_wr_ptr_q == TX_PTR_LAST) ? '0 : tx_wr_ptr_q + TX_AW'(1);
			end
			if (tx_ctl.pop) begin
				tx_rd_ptr_q <= (tx_rd_ptr_q == TX_PTR_LAST) ? '0 : tx_rd_ptr_q + TX_AW'(1);
			end
			if (rx_ev.push) begin
				rx_wr_ptr_q <= (rx_wr_ptr_q == RX_PTR_LAST) ? '0 : rx_wr_ptr_q + RX_AW'(1);
			end
			if (rx_rd_ok) begin
				rx_rd_ptr_q <= (rx_rd_ptr_q == RX_PTR_LAST) ? '0 : rx_rd_ptr_q + RX_AW'(1);
			end
			tx_fill_q <= tx_fill_d;
			rx_fill_q <= rx_fill_d;
		end
	end

	// Stage one: result fields while the receive memory read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pin_s1      <= tx_ctl.pin_next;
			status_s1   <= status_d;
			tx_level_s1 <= 5'(tx_fill_d);
			rx_level_s1 <= 5'(rx_fill_d);
			rd_ok_s1    <= rx_rd_ok;
		end
	end

	// Output register; the read word is picked up from the memory port here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			tx_line_q   <= pin_s1;
			read_data_q <= rd_ok_s1 ? rx_rdata : 8'd0;
			status_q    <= status_s1;
			tx_level_q  <= tx_level_s1;
			rx_level_q  <= rx_level_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign tx_line   = tx_line_q;
	assign read_data = read_data_q;
	assign status    = status_q;
	assign tx_level  = tx_level_q;
	assign rx_level  = rx_level_q;

`ifndef SYNTHESIS
	// The fill counts never pass the FIFO depths.
	a_tx_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tx_fill_q <= TX_FULL_LVL)
		else $error("transmit fill count above depth");

	a_rx_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rx_fill_q <= RX_FULL_LVL)
		else $error("receive fill count above depth");

	// The transmitter pops only a non-empty FIFO, and only on a tick.
	a_tx_pop_legal: assert property (@(posedge clk) disable iff (!arst_n)
		tx_ctl.pop |-> (tick && tx_fill_q != '0))
		else $error("transmit pop without a word or tick");

	// The receiver never pushes into a full FIFO.
	a_rx_push_legal: assert property (@(posedge clk) disable iff (!arst_n)
		rx_ev.push |-> (tick && !rx_full))
		else $error("receive push into a full FIFO");

	// A result word whose status is not OK carries zero read data.
	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |-> (read_data_q == 8'd0))
		else $error("failed item carries read data");
`endif

endmodule

### src/u4x_ram.sv
module u4x_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single write port and a registered read port that holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/u4x_tx.sv
module u4x_tx (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick,
	input  logic              avail,
	input  logic [7:0]        fifo_data,
	output u4x_pkg::tx_ctl_t  ctl
);
	import u4x_pkg::*;

	logic [1:0] phase_q, phase_d;
	logic [5:0] tick_q, tick_d;
	logic [7:0] shift_q, shift_d;
	logic       pin_q, pin_d;
	logic       load_q;
	logic       pop;

	// Frame sequencer: start bit, eight data bits LSB first, stop bit.
	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		shift_d = shift_q;
		pin_d   = pin_q;
		pop     = 1'b0;
		// The popped word arrives from the registered memory read port in the cycle after the pop.
		if (load_q) begin
			shift_d = fifo_data;
		end
		if (tick) begin
			case (phase_q)
				PH_IDLE: begin
					if (avail) begin
						pop     = 1'b1;
						tick_d  = '0;
						phase_d = PH_START;
					end
				end
				PH_START: begin
					if (tick_q == '0) begin
						pin_d = 1'b0;
					end
					if (tick_q == TX_START_LAST) begin
						phase_d = PH_DATA;
					end
					tick_d = tick_q + 6'd1;
				end
				PH_DATA: begin
					if (tick_q == DATA_LAST) begin
						phase_d = PH_STOP;
					end else if (tick_q[1:0] == TX_BIT_OFS) begin
						pin_d   = shift_q[0];
						shift_d = {1'b0, shift_q[7:1]};
					end
					tick_d = tick_q + 6'd1;
				end
				default: begin
					if (tick_q == STOP_LAST) begin
						phase_d = PH_IDLE;
					end else if (tick_q == TX_STOP_EDGE) begin
						pin_d = 1'b1;
					end
					tick_d = tick_q + 6'd1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			shift_q <= '0;
			pin_q   <= 1'b1;
			load_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			shift_q <= shift_d;
			pin_q   <= pin_d;
			load_q  <= pop;
		end
	end

	assign ctl.pop      = pop;
	assign ctl.pin_next = pin_d;

endmodule

### src/u4x_rx.sv
module u4x_rx (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tick,
	input  logic             line,
	input  logic             full,
	output u4x_pkg::rx_ev_t  ev
);
	import u4x_pkg::*;

	logic [1:0] phase_q, phase_d;
	logic [5:0] tick_q, tick_d;
	logic [7:0] shift_q, shift_d;
	logic       push;

	// Start detection with glitch rejection, mid-bit sampling, stop check.
	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		shift_d = shift_q;
		push    = 1'b0;
		if (tick) begin
			case (phase_q)
				PH_IDLE: begin
					if (!line) begin
						tick_d  = 6'd1;
						shift_d = '0;
						phase_d = PH_START;
					end
				end
				PH_START: begin
					if (tick_q == RX_START_LAST) begin
						phase_d = PH_DATA;
					end
					if (line) begin
						phase_d = PH_IDLE;
					end
					tick_d = tick_q + 6'd1;
				end
				PH_DATA: begin
					if (tick_q == DATA_LAST) begin
						phase_d = PH_STOP;
					end else if (tick_q[1:0] == RX_SAMPLE_OFS) begin
						shift_d = {line, shift_q[7:1]};
					end
					tick_d = tick_q + 6'd1;
				end
				default: begin
					if (tick_q == RX_STOP_SAMPLE) begin
						push = line && !full;
					end else if (tick_q == STOP_LAST) begin
						phase_d = PH_IDLE;
					end
					tick_d = tick_q + 6'd1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			shift_q <= '0;
		end else begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			shift_q <= shift_d;
		end
	end

	assign ev.push = push;
	assign ev.data = shift_q;

endmodule
